// File: rtl/core/cll_pkg.sv
package cll_pkg;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 9;

  // Opcodes; the two unused codes act as a query.
  localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_NEXT   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_PREV   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_QUERY  = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd5;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LINK = 4'b0010,
    S_VAL  = 4'b0100,
    S_DONE = 4'b1000
  } cll_state_e;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [VALUE_W-1:0]  insert_value;
  } cll_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  removed_value;
    logic [VALUE_W-1:0]  current_value;
    logic                current_valid;
    logic [COUNT_W-1:0]  item_count;
  } cll_out_t;

endpackage

// File: rtl/core/cll_ram.sv
module cll_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/circular_list_with_cursor.sv
// Circular doubly linked list with a cursor, up to CAPACITY entries. Each
// input beat carries an opcode (insert after cursor, delete at cursor, next,
// previous, query, clear) and gives exactly one result beat with status,
// removed value, value at the cursor, a non-empty flag and the entry count.
// Values, next links, previous links and the stack of freed slots each sit in
// a one-write, one-read RAM with a registered read port; the cursor value is
// kept in a register. A small sequencer drives these ports in steps
// and the block takes one item at a time: insert, delete, next and
// previous pass through a link read, then a second write or value read, then
// the result load before the next accept; a delete that empties the list skips
// the value read, and query, clear and refused operations go straight to the
// result load. The result sits in an output register, so the sequencer stalls
// in its last step only while an earlier result is not yet taken. No clearing
// pass is needed after reset.
module circular_list_with_cursor
  import cll_pkg::*;
#(
  parameter int unsigned CAPACITY   = 256,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  cll_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output cll_out_t out_data_o
);

  localparam int unsigned SW = $clog2(CAPACITY);      // slot index width
  localparam int unsigned CW = $clog2(CAPACITY + 1);  // count width
  localparam int unsigned VW = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;

  // Sequencer and list state
  cll_state_e state_q, state_d;
  logic [SW-1:0] cur_q, cur_d;           // cursor slot
  logic [CW-1:0] count_q, count_d;       // entries in list
  logic [CW-1:0] ftop_q, ftop_d;         // freed-slot stack depth
  logic [CW-1:0] nun_q, nun_d;           // next never-used slot
  logic [VW-1:0] curval_q, curval_d;     // value at cursor, zero when empty

  // Per-item working registers
  logic [OPCODE_W-1:0] op_q, op_d;
  logic [VW-1:0]       val_q, val_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [VW-1:0]       removed_q, removed_d;
  logic [SW-1:0]       slot_q, slot_d;
  logic [SW-1:0]       after_q, after_d;

  // Result register
  logic     out_valid_q, out_valid_d;
  cll_out_t out_q, out_d;

  // RAM ports
  logic          val_we, nxt_we, prv_we, frd_we;
  logic [SW-1:0] val_waddr, nxt_waddr, prv_waddr, frd_waddr;
  logic [VW-1:0] val_wdata;
  logic [SW-1:0] nxt_wdata, prv_wdata, frd_wdata;
  logic [SW-1:0] val_raddr, link_raddr, frd_raddr;
  logic [VW-1:0] val_rdata;
  logic [SW-1:0] nxt_rdata, prv_rdata, frd_rdata;

  logic          accept;
  logic          empty;
  logic          full;
  logic          out_free;
  logic [CW-1:0] ftop_dec;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign empty      = (count_q == '0);
  assign full       = (count_q >= CW'(CAPACITY));
  assign out_free   = !out_valid_q || out_ready_i;
  assign ftop_dec   = ftop_q - CW'(1);

  // Both link RAMs are read at the cursor on accept; the freed stack at its top.
  assign link_raddr = cur_q;
  assign frd_raddr  = ftop_dec[SW-1:0];

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    count_d     = count_q;
    ftop_d      = ftop_q;
    nun_d       = nun_q;
    curval_d    = curval_q;
    op_d        = op_q;
    val_d       = val_q;
    status_d    = status_q;
    removed_d   = removed_q;
    slot_d      = slot_q;
    after_d     = after_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    val_we    = 1'b0;
    val_waddr = slot_q;
    val_wdata = val_q;
    val_raddr = cur_q;
    nxt_we    = 1'b0;
    nxt_waddr = slot_q;
    nxt_wdata = slot_q;
    prv_we    = 1'b0;
    prv_waddr = slot_q;
    prv_wdata = slot_q;
    frd_we    = 1'b0;
    frd_waddr = ftop_q[SW-1:0];
    frd_wdata = cur_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d      = in_data_i.opcode;
          val_d     = in_data_i.insert_value[VW-1:0];
          removed_d = '0;
          status_d  = STAT_OK;
          state_d   = S_DONE;
          case (in_data_i.opcode)
            OP_INSERT: begin
              if (full) begin
                status_d = STAT_FULL;
              end else begin
                state_d = S_LINK;
              end
            end
            OP_DELETE, OP_NEXT, OP_PREV: begin
              if (empty) begin
                status_d = STAT_EMPTY;
              end else begin
                state_d = S_LINK;
              end
            end
            OP_CLEAR: begin
              ftop_d   = '0;
              nun_d    = '0;
              cur_d    = '0;
              count_d  = '0;
              curval_d = '0;
            end
            default: begin
              if (empty) begin
                status_d = STAT_EMPTY;
              end
            end
          endcase
        end
      end

      S_LINK: begin
        state_d = S_VAL;
        case (op_q)
          OP_INSERT: begin
            // Take a freed slot first, else a never-used one; link it to itself
            // or between the cursor and its successor.
            if (ftop_q != '0) begin
              slot_d = frd_rdata;
              ftop_d = ftop_dec;
            end else begin
              slot_d = nun_q[SW-1:0];
              nun_d  = nun_q + CW'(1);
            end
            after_d   = nxt_rdata;
            val_we    = 1'b1;
            val_waddr = slot_d;
            val_wdata = val_q;
            nxt_we    = 1'b1;
            nxt_waddr = slot_d;
            nxt_wdata = empty ? slot_d : nxt_rdata;
            prv_we    = 1'b1;
            prv_waddr = slot_d;
            prv_wdata = empty ? slot_d : cur_q;
            curval_d  = val_q;
          end
          OP_DELETE: begin
            // Push the cursor slot on the freed stack and unlink it.
            removed_d = curval_q;
            frd_we    = (ftop_q < CW'(CAPACITY));
            ftop_d    = ftop_q + CW'(1);
            count_d   = count_q - CW'(1);
            if (count_q == CW'(1)) begin
              cur_d    = '0;
              curval_d = '0;
              state_d  = S_DONE;
            end else begin
              prv_we    = 1'b1;
              prv_waddr = nxt_rdata;
              prv_wdata = prv_rdata;
              nxt_we    = 1'b1;
              nxt_waddr = prv_rdata;
              nxt_wdata = nxt_rdata;
              cur_d     = nxt_rdata;
              val_raddr = nxt_rdata;
            end
          end
          default: begin
            // Next or previous: advance the cursor and fetch its value.
            cur_d     = (op_q == OP_NEXT) ? nxt_rdata : prv_rdata;
            val_raddr = cur_d;
          end
        endcase
      end

      S_VAL: begin
        state_d = S_DONE;
        if (op_q == OP_INSERT) begin
          // Close the ring around the new slot, then move the cursor onto it.
          if (!empty) begin
            nxt_we    = 1'b1;
            nxt_waddr = cur_q;
            nxt_wdata = slot_q;
            prv_we    = 1'b1;
            prv_waddr = after_q;
            prv_wdata = slot_q;
          end
          cur_d   = slot_q;
          count_d = count_q + CW'(1);
        end else begin
          curval_d = val_rdata;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.status        = status_q;
          out_d.removed_value = VALUE_W'(removed_q);
          out_d.current_value = VALUE_W'(curval_q);
          out_d.current_valid = !empty;
          out_d.item_count    = COUNT_W'(count_q);
          state_d             = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      count_q     <= '0;
      ftop_q      <= '0;
      nun_q       <= '0;
      curval_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      count_q     <= count_d;
      ftop_q      <= ftop_d;
      nun_q       <= nun_d;
      curval_q    <= curval_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold per-item payload; no reset needed.
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    val_q     <= val_d;
    status_q  <= status_d;
    removed_q <= removed_d;
    slot_q    <= slot_d;
    after_q   <= after_d;
    out_q     <= out_d;
  end

  cll_ram #(.WIDTH(VW), .DEPTH(CAPACITY)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

  cll_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_waddr),
    .wdata_i (nxt_wdata),
    .raddr_i (link_raddr),
    .rdata_o (nxt_rdata)
  );

  cll_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prv_we),
    .waddr_i (prv_waddr),
    .wdata_i (prv_wdata),
    .raddr_i (link_raddr),
    .rdata_o (prv_rdata)
  );

  cll_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_freed_ram (
    .clk_i   (clk_i),
    .we_i    (frd_we),
    .waddr_i (frd_waddr),
    .wdata_i (frd_wdata),
    .raddr_i (frd_raddr),
    .rdata_o (frd_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/core/cll_checker.sv
module cll_checker
  import cll_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input cll_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input cll_out_t out_data_o
);

  // One item at a time: busy right after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted a beat while busy");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // An empty list reports no entries and no cursor value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.current_valid |->
      out_data_o.item_count == '0 && out_data_o.current_value == '0)
    else $error("empty list with count or value");

  // A full refusal removes nothing and leaves a populated list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STAT_FULL |->
      out_data_o.removed_value == '0 && out_data_o.current_valid)
    else $error("bad full refusal");

  // Only a successful delete reports a removed value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.removed_value != '0 |-> out_data_o.status == STAT_OK)
    else $error("removed value on refused operation");

endmodule

bind circular_list_with_cursor cll_checker u_cll_checker (.*);
